@@ sv/lfcp_pkg.sv @@
// ----------------------------------------------------------------------------
// lfcp_pkg
// shared types, widths, register indexes and the control program of the
// line-follow cascaded pid block
// ----------------------------------------------------------------------------
package lfcp_pkg;

  // field and register widths
  localparam int GAIN_W   = 10;
  localparam int NGAINS   = 6;
  localparam int CFG_W    = GAIN_W * NGAINS;
  localparam int IDX_W    = 3;
  localparam int LEVEL_W  = 7;
  localparam int BYTE_W   = 8;
  localparam int TGT_W    = 16;
  localparam int IN_W     = 8;
  localparam int OUT_W    = 24;

  // per-mode loop state
  localparam int STEER_PREV_W = 10;
  localparam int STEER_INT_W  = 32;
  localparam int SPEED_PREV_W = 24;
  localparam int SPEED_INT_W  = 40;

  // shared multiply-accumulate datapath
  localparam int OPND_W = 25;
  localparam int INT_W  = SPEED_INT_W;
  localparam int SPLIT  = 20;
  localparam int PROD_W = GAIN_W + OPND_W;
  localparam int ACC_W  = 56;

  // register indexes
  localparam logic [IDX_W-1:0] REG_REF_OFFSET     = 3'd0;
  localparam logic [IDX_W-1:0] REG_NORMAL_TARGETS = 3'd1;
  localparam logic [IDX_W-1:0] REG_SEARCH_TARGETS = 3'd2;
  localparam logic [IDX_W-1:0] REG_NORMAL_GAINS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_SEARCH_GAINS   = 3'd4;
  localparam logic [IDX_W-1:0] REG_MIN_SPEED      = 3'd5;
  localparam logic [IDX_W-1:0] REG_STEER_TARGET   = 3'd6;

  // special operations of a step
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_E1   = 3'd1;  // steering error from the sample
  localparam logic [2:0] OP_INT  = 3'd2;  // difference, integral, state update
  localparam logic [2:0] OP_E2   = 3'd3;  // speed error and steer result
  localparam logic [2:0] OP_ABS  = 3'd4;  // magnitude of speed pid output
  localparam logic [2:0] OP_SPD  = 3'd5;  // speed candidate with floor
  localparam logic [2:0] OP_OUT  = 3'd6;  // hand result to output register

  // gain within the current pass
  localparam logic [1:0] G_P = 2'd0;
  localparam logic [1:0] G_I = 2'd1;
  localparam logic [1:0] G_D = 2'd2;

  // multiplier operand
  localparam logic [1:0] B_ERR  = 2'd0;
  localparam logic [1:0] B_ILO  = 2'd1;
  localparam logic [1:0] B_IHI  = 2'd2;
  localparam logic [1:0] B_DIFF = 2'd3;

  // accumulator operation
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // jump conditions
  localparam logic [1:0] JMP_NONE   = 2'd0;
  localparam logic [1:0] JMP_ALWAYS = 2'd1;
  localparam logic [1:0] JMP_PASS   = 2'd2;

  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_LOOP  = 4'd1;
  localparam logic [PC_W-1:0] PC_FINAL = 4'd8;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd10;

  typedef struct packed {
    logic [2:0]      op;
    logic            mul_en;
    logic [1:0]      gsel;
    logic [1:0]      bsel;
    logic [1:0]      acc_op;
    logic            acc_shift;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ref_offset;
    logic [TGT_W-1:0]  normal_targets;
    logic [TGT_W-1:0]  search_targets;
    logic [CFG_W-1:0]  normal_gains;
    logic [CFG_W-1:0]  search_gains;
    logic [BYTE_W-1:0] min_speed;
    logic [BYTE_W-1:0] steer_target;
  } cfg_t;

  // control program: steering pass, then the same mac steps as speed pass
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    case (pc)
      4'd0: c.op = OP_E1;
      4'd1: c.op = OP_INT;
      4'd2: begin
        c.mul_en = 1'b1; c.gsel = G_P; c.bsel = B_ERR;
      end
      4'd3: begin
        c.mul_en = 1'b1; c.gsel = G_I; c.bsel = B_ILO; c.acc_op = ACC_LOAD;
      end
      4'd4: begin
        c.mul_en = 1'b1; c.gsel = G_I; c.bsel = B_IHI; c.acc_op = ACC_ADD;
      end
      4'd5: begin
        c.mul_en = 1'b1; c.gsel = G_D; c.bsel = B_DIFF; c.acc_op = ACC_ADD;
        c.acc_shift = 1'b1;
      end
      4'd6: begin
        c.acc_op = ACC_ADD; c.jmp = JMP_PASS; c.target = PC_FINAL;
      end
      4'd7: begin
        c.op = OP_E2; c.jmp = JMP_ALWAYS; c.target = PC_LOOP;
      end
      4'd8: c.op = OP_ABS;
      4'd9: c.op = OP_SPD;
      4'd10: c.op = OP_OUT;
      default: begin
        c.jmp = JMP_ALWAYS; c.target = PC_OUT;
      end
    endcase
    return c;
  endfunction

endpackage

@@ sv/lfcp_datapath.sv @@
// ----------------------------------------------------------------------------
// lfcp_datapath
// shared multiply-accumulate datapath and per-mode loop state, driven one
// control word per cycle
// ----------------------------------------------------------------------------
module lfcp_datapath #(
  parameter int GAIN_FRAC_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lfcp_pkg::ctrl_t              ctrl,
  input  logic                         start,
  input  logic                         in_mode,
  input  logic [lfcp_pkg::LEVEL_W-1:0] in_level,
  input  lfcp_pkg::cfg_t               cfg,
  output logic                         pass,
  output logic [lfcp_pkg::BYTE_W-1:0]  speed,
  output logic [lfcp_pkg::BYTE_W-1:0]  steer
);
  import lfcp_pkg::*;

  localparam int F  = GAIN_FRAC_BITS;
  localparam int F2 = 2 * GAIN_FRAC_BITS;
  localparam int WW = ACC_W + 1;

  localparam logic [ACC_W-1:0] RND1 = ACC_W'((64'd1 << F) - 64'd1);
  localparam logic [ACC_W-1:0] RND2 = ACC_W'((64'd1 << F2) - 64'd1);
  localparam logic signed [ACC_W-1:0] ZERO_A = 0;

  localparam logic signed [INT_W:0] ONE_I   = 1;
  localparam logic signed [INT_W:0] I32_MAX = (ONE_I <<< (STEER_INT_W - 1)) - ONE_I;
  localparam logic signed [INT_W:0] I32_MIN = -(ONE_I <<< (STEER_INT_W - 1));
  localparam logic signed [INT_W:0] I40_MAX = (ONE_I <<< (SPEED_INT_W - 1)) - ONE_I;
  localparam logic signed [INT_W:0] I40_MIN = -(ONE_I <<< (SPEED_INT_W - 1));

  localparam logic signed [WW-1:0] ONE_W   = 1;
  localparam logic signed [WW-1:0] E24_MAX = (ONE_W <<< (SPEED_PREV_W - 1)) - ONE_W;
  localparam logic signed [WW-1:0] E24_MIN = -(ONE_W <<< (SPEED_PREV_W - 1));

  localparam logic signed [ACC_W-1:0] S8_MAX = 127;
  localparam logic signed [ACC_W-1:0] S8_MIN = -128;

  function automatic logic [BYTE_W-1:0] sat8(input logic signed [ACC_W-1:0] v);
    logic [BYTE_W-1:0] r;
    if (v > S8_MAX) r = 8'h7f;
    else if (v < S8_MIN) r = 8'h80;
    else r = v[BYTE_W-1:0];
    return r;
  endfunction

  // item and working registers
  logic                           mode;
  logic [LEVEL_W-1:0]             level;
  logic signed [OPND_W-1:0]       err;
  logic signed [OPND_W-1:0]       diff;
  logic signed [INT_W-1:0]        integ;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic [BYTE_W-1:0]              steer_r;

  // loop state, one entry per mode
  logic signed [STEER_PREV_W-1:0] steer_prev [2];
  logic signed [STEER_INT_W-1:0]  steer_int  [2];
  logic signed [SPEED_PREV_W-1:0] speed_prev [2];
  logic signed [SPEED_INT_W-1:0]  speed_int  [2];

  logic [TGT_W-1:0]               tg;
  logic [CFG_W-1:0]               gs;
  logic signed [STEER_PREV_W-1:0] sample;
  logic signed [STEER_PREV_W-1:0] e1;
  logic signed [OPND_W-1:0]       prev_sel;
  logic signed [INT_W-1:0]        int_sel;
  logic signed [INT_W:0]          isum;
  logic signed [INT_W-1:0]        isat;
  logic [2:0]                     gk;
  logic signed [GAIN_W-1:0]       gain;
  logic signed [OPND_W-1:0]       opnd;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [WW-1:0]           e2_full;
  logic signed [OPND_W-1:0]       e2_sat;
  logic signed [ACC_W-1:0]        tr1;
  logic signed [ACC_W-1:0]        tr2;
  logic signed [WW-1:0]           sp;
  logic signed [WW-1:0]           fl;

  always_comb begin
    tg = mode ? cfg.search_targets : cfg.normal_targets;
    gs = mode ? cfg.search_gains : cfg.normal_gains;

    // steering error, ten bits hold every case
    sample = $signed({3'b000, level}) + STEER_PREV_W'($signed(cfg.ref_offset));
    e1     = $signed({2'b00, tg[BYTE_W-1:0]}) - sample;

    // state of the current pass
    if (pass) begin
      prev_sel = OPND_W'(speed_prev[mode]);
      int_sel  = speed_int[mode];
    end else begin
      prev_sel = OPND_W'(steer_prev[mode]);
      int_sel  = INT_W'(steer_int[mode]);
    end
    isum = (INT_W+1)'(int_sel) + (INT_W+1)'(err);
    if (pass) begin
      if (isum > I40_MAX) isat = INT_W'(I40_MAX);
      else if (isum < I40_MIN) isat = INT_W'(I40_MIN);
      else isat = isum[INT_W-1:0];
    end else begin
      if (isum > I32_MAX) isat = INT_W'(I32_MAX);
      else if (isum < I32_MIN) isat = INT_W'(I32_MIN);
      else isat = isum[INT_W-1:0];
    end

    // multiplier operands; wide integral goes through in two halves
    gk   = {1'b0, ctrl.gsel} + (pass ? 3'd3 : 3'd0);
    gain = $signed(gs[GAIN_W*gk +: GAIN_W]);
    case (ctrl.bsel)
      B_ERR:   opnd = err;
      B_ILO:   opnd = $signed({{(OPND_W-SPLIT){1'b0}}, integ[SPLIT-1:0]});
      B_IHI:   opnd = OPND_W'($signed(integ[INT_W-1:SPLIT]));
      B_DIFF:  opnd = diff;
      default: opnd = err;
    endcase
    prod_ext = ACC_W'(prod);

    // speed error from raw steering value
    e2_full = (WW'($signed(cfg.steer_target)) <<< F) - WW'(acc);
    if (e2_full > E24_MAX) e2_sat = OPND_W'(E24_MAX);
    else if (e2_full < E24_MIN) e2_sat = OPND_W'(E24_MIN);
    else e2_sat = e2_full[OPND_W-1:0];

    // truncation toward zero
    tr1 = (acc + (acc[ACC_W-1] ? $signed(RND1) : ZERO_A)) >>> F;
    tr2 = (acc + (acc[ACC_W-1] ? $signed(RND2) : ZERO_A)) >>> F2;

    // speed candidate and floor
    sp = (WW'($signed(tg[TGT_W-1:BYTE_W])) <<< F2) - WW'(acc);
    fl = WW'($signed(cfg.min_speed)) <<< F2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        steer_prev[i] <= '0;
        steer_int[i]  <= '0;
        speed_prev[i] <= '0;
        speed_int[i]  <= '0;
      end
    end else begin
      if (start) begin
        mode  <= in_mode;
        level <= in_level;
        pass  <= 1'b0;
      end

      case (ctrl.op)
        OP_E1: err <= OPND_W'(e1);
        OP_INT: begin
          diff  <= err - prev_sel;
          integ <= isat;
          if (pass) begin
            speed_prev[mode] <= err[SPEED_PREV_W-1:0];
            speed_int[mode]  <= isat;
          end else begin
            steer_prev[mode] <= err[STEER_PREV_W-1:0];
            steer_int[mode]  <= isat[STEER_INT_W-1:0];
          end
        end
        OP_E2: begin
          err     <= e2_sat;
          steer_r <= sat8(tr1);
          pass    <= 1'b1;
        end
        OP_ABS: acc <= acc[ACC_W-1] ? -acc : acc;
        OP_SPD: acc <= (sp < fl) ? fl[ACC_W-1:0] : sp[ACC_W-1:0];
        default: ;
      endcase

      if (ctrl.mul_en) prod <= PROD_W'(gain) * PROD_W'(opnd);

      case (ctrl.acc_op)
        ACC_LOAD: acc <= prod_ext;
        ACC_ADD:  acc <= acc + (ctrl.acc_shift ? (prod_ext <<< SPLIT) : prod_ext);
        default: ;
      endcase
    end
  end

  assign speed = sat8(tr2);
  assign steer = steer_r;

endmodule

@@ sv/line_follow_cascaded_pid.sv @@
// ----------------------------------------------------------------------------
// line_follow_cascaded_pid
// two-loop pid controller for line tracing: steering loop on reflectance,
// speed loop on steering, separate state and gains for normal and search mode
// ----------------------------------------------------------------------------
// One item is in flight at a time. After a word is accepted the block runs an
// eleven-word control program through a single shared 10 x 25 multiplier,
// seventeen steps in all: the steering error, then the integral step and five
// multiply/accumulate steps for the steering pid (the wide integral goes
// through the multiplier as two halves), one step for the speed error, the
// integral step and the same five steps again for the speed pid, then
// magnitude, floor and output steps. The result word is registered at the
// output step, and the input side is ready again in the same cycle that
// the result appears, so a new word is taken only once the previous word's
// program is through. A finished result waits in the output register without
// holding the sequencer, so the next input may be accepted and computed
// meanwhile; only its output step waits until the register is free.
// Configuration is taken at any time through the write port and should only
// change while no word is being worked on.
// ----------------------------------------------------------------------------
module line_follow_cascaded_pid #(
  parameter int GAIN_FRAC_BITS = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_wen,
  input  logic [lfcp_pkg::IDX_W-1:0] cfg_addr,
  input  logic [lfcp_pkg::CFG_W-1:0] cfg_wdata,
  // input words
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [lfcp_pkg::IN_W-1:0]  s_tdata,   // [6:0] reflection_level, [7] zero
  input  logic [0:0]                 s_tuser,   // [0] search_mode
  // result words
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [lfcp_pkg::OUT_W-1:0] m_tdata    // [7:0] speed, [15:8] steer,
                                                // [16] centered, [23:17] zero
);
  import lfcp_pkg::*;

  // configuration registers
  cfg_t cfg;

  // sequencer
  logic              busy;
  logic [PC_W-1:0]   pc;
  ctrl_t             uword;
  ctrl_t             ctrl;
  logic              start;
  logic              out_free;
  logic              take;
  logic              pass;
  logic [BYTE_W-1:0] speed_val;
  logic [BYTE_W-1:0] steer_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_REF_OFFSET:     cfg.ref_offset     <= cfg_wdata[BYTE_W-1:0];
        REG_NORMAL_TARGETS: cfg.normal_targets <= cfg_wdata[TGT_W-1:0];
        REG_SEARCH_TARGETS: cfg.search_targets <= cfg_wdata[TGT_W-1:0];
        REG_NORMAL_GAINS:   cfg.normal_gains   <= cfg_wdata;
        REG_SEARCH_GAINS:   cfg.search_gains   <= cfg_wdata;
        REG_MIN_SPEED:      cfg.min_speed      <= cfg_wdata[BYTE_W-1:0];
        REG_STEER_TARGET:   cfg.steer_target   <= cfg_wdata[BYTE_W-1:0];
        default: ;  // unknown index, dropped
      endcase
    end
  end

  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;

  // the program word only reaches the datapath while an item is running
  assign uword    = ucode(pc);
  assign ctrl     = busy ? uword : '0;
  assign out_free = !m_tvalid || m_tready;
  assign take     = busy && (uword.op == OP_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (busy) begin
      if (uword.op == OP_OUT) begin
        // last step waits here until the output register is free
        if (out_free) busy <= 1'b0;
      end else if (uword.jmp == JMP_ALWAYS || (uword.jmp == JMP_PASS && pass)) begin
        pc <= uword.target;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  lfcp_datapath #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .start    (start),
    .in_mode  (s_tuser[0]),
    .in_level (s_tdata[LEVEL_W-1:0]),
    .cfg      (cfg),
    .pass     (pass),
    .speed    (speed_val),
    .steer    (steer_val)
  );

  // output register, holds a word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {{(OUT_W-2*BYTE_W-1){1'b0}}, (steer_val == '0), steer_val, speed_val};
    end
  end

endmodule

@@ sv/lfcp_checker.sv @@
// ----------------------------------------------------------------------------
// lfcp_checker
// port-level checks of the line-follow cascaded pid block, bound to its top
// ----------------------------------------------------------------------------
module lfcp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [lfcp_pkg::OUT_W-1:0] m_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // centered flag agrees with steer field
  a_centered: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16] == (m_tdata[15:8] == 8'h00)))
    else $error("centered flag does not match steer");

  // while the program of a taken word runs, the input side is not ready
  a_busy_span: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> ##11 !s_tready)
    else $error("input accepted before program finished");

  // a new result appears exactly when the sequencer frees up
  a_result_ready: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result appeared while program still running");

endmodule

bind line_follow_cascaded_pid lfcp_checker u_chk (.*);

@@ tb/line_follow_cascaded_pid_tb.sv @@
// ----------------------------------------------------------------------------
// line_follow_cascaded_pid_tb
// self-checking bench for the two-loop line-follow pid: input words are
// streamed in from a queue, every result word is checked against a cycle-free
// model of both pid loops with per-mode state, over several register settings
// ----------------------------------------------------------------------------
module line_follow_cascaded_pid_tb;
  import lfcp_pkg::*;

  localparam int FRAC_BITS   = 6;     // gain fraction bits of the block
  localparam int HOLD_CYCLES = 400;   // long output back-pressure stretch
  localparam int STALL_LIMIT = 5000;  // cycles with no handshake before giving up
  localparam int SETTLE      = 16;    // quiet cycles after the last result

  // index that maps to no register, writes to it must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic               mode;
    logic [LEVEL_W-1:0] level;
  } sample_t;

  typedef struct packed {
    logic signed [7:0] speed;
    logic signed [7:0] steer;
    logic              centered;
  } cmd_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // block inputs, all known from time zero
  logic              cfg_wen   = 1'b0;
  logic [IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata   = '0;  // [6:0] reflection_level, [7] zero
  logic [0:0]        s_tuser   = '0;  // [0] search_mode
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;         // [7:0] speed, [15:8] steer, [16] centered

  line_follow_cascaded_pid #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // pending samples and expected motor commands
  sample_t sample_q[$];
  cmd_t    cmd_q[$];

  // idle percentages of each side, changed between phases
  int src_idle = 23;
  int snk_idle = 73;

  // back-pressure request, toggled by the stimulus, served by the receiver
  logic hold_go   = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int   n_bad = 0;
  int   quiet = 0;
  logic run_mode = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor: register copy and per-mode loop state
  // ---------------------------------------------------------------------------
  cfg_t cfg_m = '0;

  logic signed [STEER_PREV_W-1:0] steer_last [2] = '{'0, '0};
  logic signed [STEER_INT_W-1:0]  steer_sum  [2] = '{'0, '0};
  logic signed [SPEED_PREV_W-1:0] speed_last [2] = '{'0, '0};
  logic signed [SPEED_INT_W-1:0]  speed_sum  [2] = '{'0, '0};

  function automatic longint clamp(longint x, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // signed q4.6 gain k out of a packed set of six
  function automatic longint gain_at(logic [CFG_W-1:0] g, int k);
    return longint'($signed(g[GAIN_W*k +: GAIN_W]));
  endfunction

  // one control tick of both loops, updates the selected mode's state
  function automatic cmd_t pid_tick(logic mode, logic [LEVEL_W-1:0] level);
    logic [TGT_W-1:0] tg;
    logic [CFG_W-1:0] gs;
    longint smp, lvl, tspd, e1, d1, raw, e2, d2, o2, sp, fl, st, spd;
    cmd_t r;
    tg   = mode ? cfg_m.search_targets : cfg_m.normal_targets;
    gs   = mode ? cfg_m.search_gains : cfg_m.normal_gains;
    smp  = longint'(level) + longint'($signed(cfg_m.ref_offset));
    lvl  = longint'(tg[7:0]);
    tspd = longint'($signed(tg[15:8]));

    // steering loop, integer error, result in q.6
    e1 = lvl - smp;
    d1 = e1 - longint'(steer_last[mode]);
    steer_sum[mode] = STEER_INT_W'(clamp(longint'(steer_sum[mode]) + e1, STEER_INT_W));
    raw = gain_at(gs, 0) * e1 + gain_at(gs, 1) * longint'(steer_sum[mode])
        + gain_at(gs, 2) * d1;
    steer_last[mode] = STEER_PREV_W'(e1);

    // speed loop on the steering output, error held at 24 bits
    e2 = clamp(longint'($signed(cfg_m.steer_target)) * (longint'(1) << FRAC_BITS)
               - raw, SPEED_PREV_W);
    d2 = e2 - longint'(speed_last[mode]);
    speed_sum[mode] = SPEED_INT_W'(clamp(longint'(speed_sum[mode]) + e2, SPEED_INT_W));
    o2 = gain_at(gs, 3) * e2 + gain_at(gs, 4) * longint'(speed_sum[mode])
       + gain_at(gs, 5) * d2;
    speed_last[mode] = SPEED_PREV_W'(e2);
    if (o2 < 0) o2 = -o2;

    // target speed less the speed correction, floored, in q.12
    sp = tspd * (longint'(1) << (2 * FRAC_BITS)) - o2;
    fl = longint'($signed(cfg_m.min_speed)) * (longint'(1) << (2 * FRAC_BITS));
    if (sp < fl) sp = fl;

    // integer division truncates toward zero
    spd = clamp(sp / (longint'(1) << (2 * FRAC_BITS)), 8);
    st  = clamp(raw / (longint'(1) << FRAC_BITS), 8);

    r.speed    = spd[7:0];
    r.steer    = st[7:0];
    r.centered = (st == 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued samples, predicts each word as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        cmd_q.push_back(pid_tick(s_tuser[0], s_tdata[LEVEL_W-1:0]));
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= src_idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {1'b0, sample_q[0].level};
          s_tuser  <= sample_q[0].mode;
          sample_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, plus one long hold when asked for
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result word against the oldest expected command
  // ---------------------------------------------------------------------------
  cmd_t got, want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.speed    = m_tdata[7:0];
      got.steer    = m_tdata[15:8];
      got.centered = m_tdata[16];
      if (cmd_q.size() == 0) begin
        if (n_bad < 10)
          $display("unexpected result word: speed %0d steer %0d centered %0d",
                   got.speed, got.steer, got.centered);
        n_bad++;
      end else begin
        want = cmd_q.pop_front();
        if (got.speed !== want.speed || got.steer !== want.steer ||
            got.centered !== want.centered) begin
          if (n_bad < 10)
            $display("mismatch exp/act: speed %0d/%0d steer %0d/%0d centered %0d/%0d",
                     want.speed, got.speed, want.steer, got.steer,
                     want.centered, got.centered);
          n_bad++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one register write, the model follows at the same edge
  task automatic set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_REF_OFFSET:     cfg_m.ref_offset     = val[BYTE_W-1:0];
      REG_NORMAL_TARGETS: cfg_m.normal_targets = val[TGT_W-1:0];
      REG_SEARCH_TARGETS: cfg_m.search_targets = val[TGT_W-1:0];
      REG_NORMAL_GAINS:   cfg_m.normal_gains   = val;
      REG_SEARCH_GAINS:   cfg_m.search_gains   = val;
      REG_MIN_SPEED:      cfg_m.min_speed      = val[BYTE_W-1:0];
      REG_STEER_TARGET:   cfg_m.steer_target   = val[BYTE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // full register set; upper data bits and the spare index carry junk
  task automatic program_regs(logic [7:0] off, logic [15:0] nt, logic [15:0] st,
                              logic [CFG_W-1:0] ng, logic [CFG_W-1:0] sg,
                              logic [7:0] mn, logic [7:0] tgt);
    set_reg(REG_REF_OFFSET,     {52'($urandom), off});
    set_reg(REG_NORMAL_TARGETS, {44'($urandom), nt});
    set_reg(REG_SEARCH_TARGETS, {44'($urandom), st});
    set_reg(REG_NORMAL_GAINS,   ng);
    set_reg(REG_SEARCH_GAINS,   sg);
    set_reg(REG_MIN_SPEED,      {52'($urandom), mn});
    set_reg(REG_STEER_TARGET,   {52'($urandom), tgt});
    set_reg(REG_SPARE,          {28'($urandom), 32'($urandom)});
    cfg_wen <= 1'b0;
  endtask

  // mostly small gains so the loops stay out of saturation, some full range
  function automatic logic [GAIN_W-1:0] pick_gain();
    if ($urandom_range(3) == 0) return GAIN_W'($urandom);
    return GAIN_W'($urandom_range(32) - 16);
  endfunction

  task automatic random_setup();
    logic [CFG_W-1:0] ng, sg;
    int k;
    for (k = 0; k < NGAINS; k++) begin
      ng[GAIN_W*k +: GAIN_W] = pick_gain();
      sg[GAIN_W*k +: GAIN_W] = pick_gain();
    end
    program_regs(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(40) - 20),
                 16'($urandom), 16'($urandom), ng, sg, 8'($urandom), 8'($urandom));
  endtask

  // samples in mode runs; most levels up to top, a few anywhere in 7 bits
  task automatic queue_samples(int n, int top);
    sample_t s;
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(7) == 0) run_mode = ~run_mode;
      s.mode  = run_mode;
      s.level = ($urandom_range(9) == 0) ? LEVEL_W'($urandom)
                                         : LEVEL_W'($urandom_range(top));
      sample_q.push_back(s);
    end
  endtask

  // wait until every offered word is taken and every result is back
  task automatic drain();
    do @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || cmd_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph, i;
    sample_t s;
    logic [LEVEL_W-1:0] lv_pick [6];
    lv_pick = '{7'd0, 7'd127, 7'd100, 7'd1, 7'd64, 7'd50};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: normal set has zero gains so steer sits at zero and speed at
    // target; search set at full positive gain drives both outputs to the rail
    program_regs(8'h00, 16'h3C32, 16'h80FF, '0, {NGAINS{10'h1FF}}, 8'h80, 8'h00);
    for (i = 0; i < 24; i++) begin
      s.mode  = 1'((i / 3) % 2);      // switch modes every third word
      s.level = lv_pick[i % 6];
      sample_q.push_back(s);
    end
    drain();

    for (ph = 0; ph < 8; ph++) begin
      // idling: sender light / receiver heavy, then swapped, then none
      src_idle <= (ph < 3) ? 23 : (ph < 6) ? 73 : 0;
      snk_idle <= (ph < 3) ? 73 : (ph < 6) ? 23 : 0;
      case (ph)
        0: program_regs(8'h7F, 16'h7FFF, 16'h7F00, {NGAINS{10'h1FF}},
                        {NGAINS{10'h200}}, 8'h7F, 8'h7F);
        1: program_regs(8'h80, 16'h8000, 16'h80FF, {NGAINS{10'h200}},
                        {NGAINS{10'h1FF}}, 8'h80, 8'h80);
        // steady large error with full integral gain winds the steering
        // output past the 24-bit speed error range
        2: program_regs(8'h9C, 16'h64C8, 16'h50C8,
                        {10'h004, 10'h001, 10'h008, 10'h008, 10'h1FF, 10'h010},
                        {10'h3FC, 10'h001, 10'h002, 10'h3F0, 10'h1FF, 10'h020},
                        8'hE2, 8'h05);
        default: random_setup();
      endcase
      queue_samples(150, (ph == 2) ? 20 : 100);
      // long receiver hold while the sender keeps offering
      if (ph == 7) begin
        @(posedge clk);
        hold_go <= ~hold_go;
      end
      drain();
    end

    if (n_bad == 0 && cmd_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
